### design/adsr_pkg.sv
// shared types and codes for the adsr envelope generator
// holds command, phase and register index codes and the control state struct
// no dependencies
package adsr_pkg;

   // command codes carried in the request beat
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_KEY_ON  = 2'd1;
   localparam logic [1:0] CMD_KEY_OFF = 2'd2;

   // envelope phase codes
   localparam logic [2:0] PH_ATTACK  = 3'd0;
   localparam logic [2:0] PH_DECAY   = 3'd1;
   localparam logic [2:0] PH_SUSTAIN = 3'd2;
   localparam logic [2:0] PH_RELEASE = 3'd3;
   localparam logic [2:0] PH_IDLE    = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN = 2'd3;

   // control part of the envelope state
   typedef struct packed {
      logic [2:0] phase;
      logic       armed;
   } adsr_ctrl_type;

endpackage

### design/adsr_cfg_regs.sv
// configuration registers of the adsr envelope generator
// clamps written values to full scale; depends on adsr_pkg
module adsr_cfg_regs
   import adsr_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FRAC_BITS:0]   csr_wdata,
   output logic [FRAC_BITS:0]   attack_step,
   output logic [FRAC_BITS:0]   decay_step,
   output logic [FRAC_BITS:0]   release_step,
   output logic [FRAC_BITS:0]   sustain_level
);

   localparam int unsigned W = FRAC_BITS + 1;
   localparam longint unsigned FullL = 64'd1 << FRAC_BITS;
   localparam logic [W-1:0] FullLevel    = W'(FullL);
   localparam logic [W-1:0] AttackReset  = W'((FullL + 64'd500) / 64'd1000);
   localparam logic [W-1:0] DecayReset   = W'((FullL + 64'd50000) / 64'd100000);
   localparam logic [W-1:0] ReleaseReset = W'((FullL + 64'd1000) / 64'd2000);
   localparam logic [W-1:0] SustainReset = W'(FullL >> 1);

   logic [W-1:0] attack_ff, decay_ff, release_ff, sustain_ff;
   logic [W-1:0] wdata_clamped;

   // anything above full scale counts as full scale
   assign wdata_clamped = (csr_wdata > FullLevel) ? FullLevel : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= AttackReset;
         decay_ff   <= DecayReset;
         release_ff <= ReleaseReset;
         sustain_ff <= SustainReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTACK:  attack_ff  <= wdata_clamped;
            CSR_DECAY:   decay_ff   <= wdata_clamped;
            CSR_RELEASE: release_ff <= wdata_clamped;
            CSR_SUSTAIN: sustain_ff <= wdata_clamped;
            default: begin
            end
         endcase
      end
   end

   assign attack_step   = attack_ff;
   assign decay_step    = decay_ff;
   assign release_step  = release_ff;
   assign sustain_level = sustain_ff;

endmodule

### design/adsr_next_state.sv
// next-state logic of the adsr envelope for one command
// one add and compare per phase; depends on adsr_pkg
module adsr_next_state
   import adsr_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic [1:0]         cmd,
   input  logic               auto_release,
   input  logic [FRAC_BITS:0] level,
   input  logic [FRAC_BITS:0] target,
   input  adsr_ctrl_type      ctrl,
   input  logic [FRAC_BITS:0] attack_step,
   input  logic [FRAC_BITS:0] decay_step,
   input  logic [FRAC_BITS:0] release_step,
   input  logic [FRAC_BITS:0] sustain_level,
   output logic [FRAC_BITS:0] level_in,
   output logic [FRAC_BITS:0] target_in,
   output adsr_ctrl_type      ctrl_in
);

   localparam int unsigned W = FRAC_BITS + 1;
   localparam logic [W-1:0] FullLevel = {1'b1, {FRAC_BITS{1'b0}}};

   logic [W:0]   atk_sum;
   logic [W:0]   dec_sum;
   logic [W-1:0] dec_diff;
   logic         reach_sus;

   assign atk_sum  = {1'b0, level} + {1'b0, attack_step};
   assign dec_sum  = {1'b0, level} + {1'b0, decay_step};
   assign dec_diff = level - sustain_level;

   always_comb begin
      level_in  = level;
      target_in = target;
      ctrl_in   = ctrl;
      reach_sus = 1'b0;
      case (cmd)
         CMD_TICK: begin
            case (ctrl.phase)
               PH_ATTACK: begin
                  if (atk_sum >= {1'b0, target}) begin
                     level_in      = target;
                     target_in     = sustain_level;
                     ctrl_in.phase = PH_DECAY;
                  end else begin
                     level_in = atk_sum[W-1:0];
                  end
               end
               PH_DECAY: begin
                  // approach sustain from above or below
                  if (level > sustain_level) begin
                     if (dec_diff <= decay_step) begin
                        reach_sus = 1'b1;
                     end else begin
                        level_in = level - decay_step;
                     end
                  end else if (dec_sum >= {1'b0, sustain_level}) begin
                     reach_sus = 1'b1;
                  end else begin
                     level_in = dec_sum[W-1:0];
                  end
                  if (reach_sus) begin
                     level_in      = sustain_level;
                     ctrl_in.phase = PH_SUSTAIN;
                     if (ctrl.armed) begin
                        ctrl_in.armed = 1'b0;
                        target_in     = '0;
                        ctrl_in.phase = PH_RELEASE;
                     end
                  end
               end
               PH_RELEASE: begin
                  if (level <= release_step) begin
                     level_in      = '0;
                     ctrl_in.phase = PH_IDLE;
                  end else begin
                     level_in = level - release_step;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_KEY_ON: begin
            ctrl_in.armed = auto_release;
            if (target == '0) begin
               target_in = FullLevel;
            end
            if (attack_step == FullLevel) begin
               level_in = FullLevel;
            end
            ctrl_in.phase = PH_ATTACK;
         end
         CMD_KEY_OFF: begin
            ctrl_in.armed = 1'b0;
            target_in     = '0;
            ctrl_in.phase = PH_RELEASE;
         end
         default: begin
         end
      endcase
   end

endmodule

### design/adsr_envelope_generator_core.sv
// top level of the linear adsr envelope generator
// input beat register, next-state logic and result register;
// depends on adsr_pkg, adsr_cfg_regs and adsr_next_state
//
// channel   direction  beat contents (lowest bits first)
// req_*     in         tdata: cmd[1:0], auto_release[2], zero fill
// rsp_*     out        tdata: level[FRAC_BITS:0], idle, zero fill
// csr_*     in         write only: csr_we, csr_index, csr_wdata
//
// one beat per cycle while rsp_tready is high; rsp_tvalid rises as stage one hands on a beat
// stage one is the input beat register, stage two the result register;
// the envelope state updates in the same cycle the result register loads
// rsp_tready low holds the result register and backs up stage one, then req_tready
// synchronous active-high reset restores register defaults and an idle envelope
module adsr_envelope_generator_core
   import adsr_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // cmd[1:0], auto_release[2]
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,   // level[FRAC_BITS:0], idle
   // configuration port
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [FRAC_BITS:0]         csr_wdata
);

   localparam int unsigned W        = FRAC_BITS + 1;
   localparam int unsigned RspBytes = (W + 1 + 7) / 8;
   localparam int unsigned RspPad   = RspBytes * 8 - W - 1;
   localparam logic [W-1:0] FullLevel = {1'b1, {FRAC_BITS{1'b0}}};

   // configuration
   logic [W-1:0] attack_step, decay_step, release_step, sustain_level;

   // stage one: captured request beat
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_cmd_ff;
   logic       s1_ar_ff;

   // envelope state
   logic [W-1:0]  level_ff, level_in;
   logic [W-1:0]  target_ff, target_in;
   adsr_ctrl_type ctrl_ff, ctrl_in;

   // stage two: result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_level_ff;
   logic         rsp_idle_ff;

   logic out_free;   // result register can load this cycle
   logic s1_fire;    // stage one beat moves to the result register
   logic req_fire;

   adsr_cfg_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .attack_step   (attack_step),
      .decay_step    (decay_step),
      .release_step  (release_step),
      .sustain_level (sustain_level)
   );

   adsr_next_state #(
      .FRAC_BITS (FRAC_BITS)
   ) u_next (
      .cmd           (s1_cmd_ff),
      .auto_release  (s1_ar_ff),
      .level         (level_ff),
      .target        (target_ff),
      .ctrl          (ctrl_ff),
      .attack_step   (attack_step),
      .decay_step    (decay_step),
      .release_step  (release_step),
      .sustain_level (sustain_level),
      .level_in      (level_in),
      .target_in     (target_in),
      .ctrl_in       (ctrl_in)
   );

   // handshake: stage one empties into the result register whenever it is free
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   // control and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         target_ff    <= '0;
         ctrl_ff      <= '{phase: PH_IDLE, armed: 1'b0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            level_ff  <= level_in;
            target_ff <= target_in;
            ctrl_ff   <= ctrl_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff <= req_tdata[1:0];
         s1_ar_ff  <= req_tdata[2];
      end
      if (s1_fire) begin
         rsp_level_ff <= level_in;
         rsp_idle_ff  <= (ctrl_in.phase == PH_IDLE);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPad{1'b0}}, rsp_idle_ff, rsp_level_ff};

`ifndef ASSERT_OFF
   // the envelope never leaves the range zero to full scale
   a_level_range : assert property (@(posedge clock) disable iff (reset)
      level_ff <= FullLevel)
      else $error("envelope level above full scale");

   // the idle phase always holds a zero level
   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.phase == PH_IDLE) |-> (level_ff == '0))
      else $error("idle phase with nonzero level");

   // a waiting stage one beat with a free result register always yields a result
   a_s1_advance : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> rsp_valid_ff)
      else $error("stage one beat lost");
`endif

endmodule
